// ----- sv/icmprc_pkg.sv -----
// Package with the shared types and constants of the ICMP reply classifier.
`timescale 1ns / 1ps
`default_nettype none

package icmprc_pkg;

    // Verdict codes carried in the result transfer.
    typedef enum logic [1:0] {
        VERDICT_IGNORED     = 2'd0,
        VERDICT_TTL_EXCEED  = 2'd1,
        VERDICT_UNREACHABLE = 2'd2,
        VERDICT_ECHO_REPLY  = 2'd3
    } verdict_t;

    // Configuration register indexes.
    localparam logic [7:0] CFG_EXPECTED_IDENT = 8'd0;
    localparam logic [7:0] CFG_EXPECTED_SEQ   = 8'd1;

    // Byte position counter saturates here.
    localparam logic [6:0] COUNT_MAX = 7'd127;

    // IPv4 header constants.
    localparam logic [3:0] IP_VERSION_4    = 4'h4;
    localparam logic [7:0] IP_PROTO_ICMP   = 8'd1;
    localparam logic [6:0] IP_HDR_MIN      = 7'd20;
    localparam logic [6:0] POS_PROTOCOL    = 7'd9;
    localparam logic [6:0] POS_SRC_FIRST   = 7'd12;
    localparam logic [6:0] POS_SRC_LAST    = 7'd15;

    // ICMP constants.
    localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;
    localparam logic [7:0] ICMP_UNREACH    = 8'h03;
    localparam logic [7:0] ICMP_TIME_EXCD  = 8'h0B;
    localparam logic [6:0] ICMP_MIN_BYTES  = 7'd8;

endpackage : icmprc_pkg

`default_nettype wire

// ----- sv/icmp_reply_classifier_core.sv -----
// Top level of the ICMP reply classifier: byte parser, verdict logic and result register.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid / s_tready  s_tdata[7:0] packet byte, s_tlast last byte
// m_        out        m_tvalid / m_tready  m_tdata[1:0] verdict, [33:2] source address
// cfg_      in         cfg_valid/cfg_ready  cfg_index register index, cfg_data value
//
// One packet byte is taken per cycle while s_tready is high; its effect on the parse
// state is registered at the same edge. A last byte loads the result register, whose
// transfer is offered on the following cycle. Reset (aresetn low, synchronous) clears
// the parse state, the expected identifier and sequence, and the result register. While
// a result waits and m_tready is low, s_tready is low; it rises in the cycle the result
// is taken. Configuration writes are taken in every cycle.

module icmp_reply_classifier_core
    import icmprc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] packet_byte
    input  wire logic        s_tlast,   // last_byte

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [1:0] verdict, [33:2] source_addr, [39:34] zero

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    // Registers.
    logic [15:0] expected_ident_reg;
    logic [15:0] expected_seq_reg;
    logic [6:0]  byte_count_reg,   byte_count_next;
    logic [5:0]  header_bytes_reg, header_bytes_next;
    logic        version_ok_reg,   version_ok_next;
    logic        protocol_ok_reg,  protocol_ok_next;
    logic [31:0] src_address_reg,  src_address_next;
    logic [7:0]  msg_type_reg,     msg_type_next;
    logic [7:0]  msg_code_reg,     msg_code_next;
    logic        echo_match_reg,   echo_match_next;
    logic        m_tvalid_reg;
    verdict_t    verdict_reg,      verdict_next;
    logic [31:0] source_addr_reg,  source_addr_next;

    logic        in_xfer;
    logic        out_xfer;
    logic [6:0]  pos;
    logic [6:0]  hdr_len;
    logic        packet_ok;

    // Handshakes: one result slot, refilled in the cycle it empties.
    assign in_xfer   = s_tvalid && s_tready;
    assign out_xfer  = m_tvalid_reg && m_tready;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, source_addr_reg, verdict_reg};

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_ident_reg <= 16'd0;
            expected_seq_reg   <= 16'd0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_EXPECTED_IDENT) begin
                expected_ident_reg <= cfg_data;
            end
            if (cfg_index == CFG_EXPECTED_SEQ) begin
                expected_seq_reg <= cfg_data;
            end
        end
    end

    // Parse of the current byte against its position in the packet.
    always_comb begin
        pos               = byte_count_reg;
        header_bytes_next = header_bytes_reg;
        version_ok_next   = version_ok_reg;
        protocol_ok_next  = protocol_ok_reg;
        src_address_next  = src_address_reg;
        msg_type_next     = msg_type_reg;
        msg_code_next     = msg_code_reg;
        echo_match_next   = echo_match_reg;

        // The first byte gives version and header length, used at once.
        if (pos == 7'd0) begin
            version_ok_next   = (s_tdata[7:4] == IP_VERSION_4);
            header_bytes_next = {s_tdata[3:0], 2'b00};
        end
        hdr_len = {1'b0, header_bytes_next};

        if (pos == POS_PROTOCOL) begin
            protocol_ok_next = (s_tdata == IP_PROTO_ICMP);
        end
        if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST) begin
            src_address_next = {src_address_reg[23:0], s_tdata};
        end

        // ICMP fields sit at offsets from the header length.
        if (pos == hdr_len) begin
            msg_type_next = s_tdata;
        end
        if (pos == hdr_len + 7'd1) begin
            msg_code_next = s_tdata;
        end
        if (pos == hdr_len + 7'd4 && s_tdata != expected_ident_reg[15:8]) begin
            echo_match_next = 1'b0;
        end
        if (pos == hdr_len + 7'd5 && s_tdata != expected_ident_reg[7:0]) begin
            echo_match_next = 1'b0;
        end
        if (pos == hdr_len + 7'd6 && s_tdata != expected_seq_reg[15:8]) begin
            echo_match_next = 1'b0;
        end
        if (pos == hdr_len + 7'd7 && s_tdata != expected_seq_reg[7:0]) begin
            echo_match_next = 1'b0;
        end

        byte_count_next = (byte_count_reg == COUNT_MAX) ? COUNT_MAX
                                                        : byte_count_reg + 7'd1;

        // Verdict from the state as it stands after this byte.
        packet_ok = version_ok_next && (hdr_len >= IP_HDR_MIN) && protocol_ok_next
                    && (byte_count_next >= hdr_len + ICMP_MIN_BYTES);
        verdict_next     = VERDICT_IGNORED;
        source_addr_next = 32'd0;
        if (packet_ok) begin
            priority if (msg_type_next == ICMP_TIME_EXCD && msg_code_next == 8'd0) begin
                verdict_next     = VERDICT_TTL_EXCEED;
                source_addr_next = src_address_next;
            end else if (msg_type_next == ICMP_UNREACH) begin
                verdict_next = VERDICT_UNREACHABLE;
            end else if (msg_type_next == ICMP_ECHO_REPLY && msg_code_next == 8'd0
                         && echo_match_next) begin
                verdict_next = VERDICT_ECHO_REPLY;
            end else begin
                verdict_next = VERDICT_IGNORED;
            end
        end
    end

    // Parse state: updated per byte, cleared after the last one.
    always_ff @(posedge aclk) begin
        if (!aresetn || (in_xfer && s_tlast)) begin
            byte_count_reg   <= 7'd0;
            header_bytes_reg <= 6'd0;
            version_ok_reg   <= 1'b0;
            protocol_ok_reg  <= 1'b0;
            src_address_reg  <= 32'd0;
            msg_type_reg     <= 8'd0;
            msg_code_reg     <= 8'd0;
            echo_match_reg   <= 1'b1;
        end else if (in_xfer) begin
            byte_count_reg   <= byte_count_next;
            header_bytes_reg <= header_bytes_next;
            version_ok_reg   <= version_ok_next;
            protocol_ok_reg  <= protocol_ok_next;
            src_address_reg  <= src_address_next;
            msg_type_reg     <= msg_type_next;
            msg_code_reg     <= msg_code_next;
            echo_match_reg   <= echo_match_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg    <= 1'b0;
            verdict_reg     <= VERDICT_IGNORED;
            source_addr_reg <= 32'd0;
        end else begin
            if (in_xfer && s_tlast) begin
                m_tvalid_reg    <= 1'b1;
                verdict_reg     <= verdict_next;
                source_addr_reg <= source_addr_next;
            end else if (out_xfer) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // A last byte always makes a result valid on the next cycle.
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && s_tlast) |=> m_tvalid_reg)
        else $error("no result after last byte");

    // The byte count, header length and echo match are back at their reset values after a last byte.
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && s_tlast) |=> (byte_count_reg == 7'd0 && echo_match_reg
                                  && header_bytes_reg == 6'd0))
        else $error("parse state not cleared after last byte");

    // The source address is only reported with a ttl exceeded verdict.
    a_addr_only_ttl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (verdict_reg == VERDICT_TTL_EXCEED || source_addr_reg == 32'd0))
        else $error("source address reported with wrong verdict");

    // The byte count advances by one on each inner byte below saturation.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && !s_tlast && byte_count_reg != COUNT_MAX)
        |=> byte_count_reg == $past(byte_count_reg) + 7'd1)
        else $error("byte count did not advance");
`endif

endmodule : icmp_reply_classifier_core

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the ICMP reply classifier core.
`timescale 1ns / 1ps

module testbench;
    import icmprc_pkg::*;

    // Run limit in clock cycles.
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 250;

    // Expected result of one packet.
    typedef struct packed {
        verdict_t    verdict;
        logic [31:0] addr;
    } reply_t;

    // Per-packet note: a typed-in reply overrides the classifier prediction.
    typedef struct packed {
        logic   use_fixed;
        reply_t want;
    } packet_note_t;

    // One row of the directed packet table.
    typedef struct packed {
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [7:0]  mtype;
        logic [7:0]  mcode;
        logic [15:0] ident;
        logic [15:0] seq;
        logic [7:0]  len;
        logic        fixed;
        verdict_t    verdict;
        logic [31:0] addr;
    } probe_t;

    // Directed packets; the registers hold their reset values of zero here.
    localparam int NUM_PROBES = 19;
    localparam probe_t PROBES [NUM_PROBES] = '{
        // Minimal echo reply that matches identifier and sequence zero.
        '{4'h4, 4'h5, 8'h01, 32'hC0A80001, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'd28,
          1'b1, VERDICT_ECHO_REPLY, 32'h0},
        // A packet of a single byte.
        '{4'hF, 4'hF, 8'hFF, 32'hFFFFFFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'd1,
          1'b1, VERDICT_IGNORED, 32'h0},
        // Time exceeded with the largest and the smallest source address.
        '{4'h4, 4'h5, 8'h01, 32'hFFFFFFFF, 8'h0B, 8'h00, 16'h1234, 16'h5678, 8'd28,
          1'b1, VERDICT_TTL_EXCEED, 32'hFFFFFFFF},
        '{4'h4, 4'h5, 8'h01, 32'h00000000, 8'h0B, 8'h00, 16'hFFFF, 16'hFFFF, 8'd28,
          1'b1, VERDICT_TTL_EXCEED, 32'h0},
        // Unreachable with any code.
        '{4'h4, 4'h5, 8'h01, 32'h0A000001, 8'h03, 8'h05, 16'hABCD, 16'hEF01, 8'd28,
          1'b1, VERDICT_UNREACHABLE, 32'h0},
        // Time exceeded and echo reply with a nonzero code.
        '{4'h4, 4'h5, 8'h01, 32'h0A000002, 8'h0B, 8'h01, 16'h0000, 16'h0000, 8'd28,
          1'b1, VERDICT_IGNORED, 32'h0},
        '{4'h4, 4'h5, 8'h01, 32'h0A000003, 8'h00, 8'hFF, 16'h0000, 16'h0000, 8'd28,
          1'b1, VERDICT_IGNORED, 32'h0},
        // Echo reply with a wrong identifier high byte, then a wrong sequence low byte.
        '{4'h4, 4'h5, 8'h01, 32'h0A000004, 8'h00, 8'h00, 16'h0100, 16'h0000, 8'd28,
          1'b1, VERDICT_IGNORED, 32'h0},
        '{4'h4, 4'h5, 8'h01, 32'h0A000005, 8'h00, 8'h00, 16'h0000, 16'h0001, 8'd28,
          1'b1, VERDICT_IGNORED, 32'h0},
        // Not version 4.
        '{4'h6, 4'h5, 8'h01, 32'h0A000006, 8'h0B, 8'h00, 16'h0000, 16'h0000, 8'd28,
          1'b1, VERDICT_IGNORED, 32'h0},
        // Header lengths of 16 and of 0 bytes.
        '{4'h4, 4'h4, 8'h01, 32'h0A000007, 8'h0B, 8'h00, 16'h0000, 16'h0000, 8'd28,
          1'b1, VERDICT_IGNORED, 32'h0},
        '{4'h4, 4'h0, 8'h01, 32'h0A000008, 8'h0B, 8'h00, 16'h0000, 16'h0000, 8'd28,
          1'b1, VERDICT_IGNORED, 32'h0},
        // Not ICMP.
        '{4'h4, 4'h5, 8'h06, 32'h0A000009, 8'h0B, 8'h00, 16'h0000, 16'h0000, 8'd28,
          1'b1, VERDICT_IGNORED, 32'h0},
        // One ICMP byte short.
        '{4'h4, 4'h5, 8'h01, 32'h0A00000A, 8'h0B, 8'h00, 16'h0000, 16'h0000, 8'd27,
          1'b1, VERDICT_IGNORED, 32'h0},
        // Largest header, just long enough and one byte short.
        '{4'h4, 4'hF, 8'h01, 32'h8000_0001, 8'h0B, 8'h00, 16'h0000, 16'h0000, 8'd68,
          1'b1, VERDICT_TTL_EXCEED, 32'h80000001},
        '{4'h4, 4'hF, 8'h01, 32'h8000_0002, 8'h0B, 8'h00, 16'h0000, 16'h0000, 8'd67,
          1'b1, VERDICT_IGNORED, 32'h0},
        // Long packet that runs the byte count into saturation.
        '{4'h4, 4'h5, 8'h01, 32'h0A00000B, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'd200,
          1'b1, VERDICT_ECHO_REPLY, 32'h0},
        // Echo request and a packet with header options, left to the classifier model.
        '{4'h4, 4'h5, 8'h01, 32'h0A00000C, 8'h08, 8'h00, 16'h0000, 16'h0000, 8'd28,
          1'b0, VERDICT_IGNORED, 32'h0},
        '{4'h4, 4'h6, 8'h01, 32'h0A00000D, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'd40,
          1'b0, VERDICT_IGNORED, 32'h0}
    };

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;   // [7:0] packet_byte
    logic        s_tlast   = 1'b0;    // last_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;             // [1:0] verdict, [33:2] source_addr, [39:34] zero
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = 8'h00;
    logic [15:0] cfg_data  = 16'h0000;

    // Classifier model state and its copy of the registers.
    logic [6:0]  cls_count;
    logic [5:0]  cls_hdr_bytes;
    logic        cls_version_ok;
    logic        cls_protocol_ok;
    logic [31:0] cls_src;
    logic [7:0]  cls_type;
    logic [7:0]  cls_code;
    logic        cls_echo_ok;
    logic [15:0] cls_ident;
    logic [15:0] cls_seq;

    reply_t       pending_replies [$];
    packet_note_t packet_notes [$];
    logic [7:0]   frame_bytes [$];
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count = 0;
    bit           stall_enable = 1'b1;

    icmp_reply_classifier_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Clears the per-packet parse state of the classifier model.
    function automatic void clear_parse();
        cls_count       = '0;
        cls_hdr_bytes   = '0;
        cls_version_ok  = 1'b0;
        cls_protocol_ok = 1'b0;
        cls_src         = '0;
        cls_type        = '0;
        cls_code        = '0;
        cls_echo_ok     = 1'b1;
    endfunction

    // Advances the classifier model by one byte; returns 1 when a verdict is due.
    function automatic bit classify_byte(input logic [7:0] b, input logic last,
                                         output reply_t reply);
        int unsigned pos;
        int unsigned hl;
        pos = cls_count;
        hl  = cls_hdr_bytes;
        reply.verdict = VERDICT_IGNORED;
        reply.addr    = '0;
        if (pos == 0) begin
            cls_version_ok = (b[7:4] == IP_VERSION_4);
            cls_hdr_bytes  = {b[3:0], 2'b00};
            hl = cls_hdr_bytes;
        end
        if (pos == POS_PROTOCOL)
            cls_protocol_ok = (b == IP_PROTO_ICMP);
        if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST)
            cls_src = {cls_src[23:0], b};
        if (pos == hl)
            cls_type = b;
        if (pos == hl + 1)
            cls_code = b;
        // Identifier and sequence are compared in wire order, high byte first.
        if (pos == hl + 4 && b != cls_ident[15:8])
            cls_echo_ok = 1'b0;
        if (pos == hl + 5 && b != cls_ident[7:0])
            cls_echo_ok = 1'b0;
        if (pos == hl + 6 && b != cls_seq[15:8])
            cls_echo_ok = 1'b0;
        if (pos == hl + 7 && b != cls_seq[7:0])
            cls_echo_ok = 1'b0;
        if (cls_count < COUNT_MAX)
            cls_count = cls_count + 7'd1;
        if (!last)
            return 1'b0;
        if (cls_version_ok && hl >= IP_HDR_MIN && cls_protocol_ok &&
            int'(cls_count) >= hl + ICMP_MIN_BYTES) begin
            if (cls_type == ICMP_TIME_EXCD && cls_code == 8'h00) begin
                reply.verdict = VERDICT_TTL_EXCEED;
                reply.addr    = cls_src;
            end else if (cls_type == ICMP_UNREACH) begin
                reply.verdict = VERDICT_UNREACHABLE;
            end else if (cls_type == ICMP_ECHO_REPLY && cls_code == 8'h00 && cls_echo_ok) begin
                reply.verdict = VERDICT_ECHO_REPLY;
            end
        end
        clear_parse();
        return 1'b1;
    endfunction

    // Builds a packet into frame_bytes; header fields win over overlapping ICMP fields.
    function automatic void fill_frame(input logic [3:0] ver, input logic [3:0] ihl,
                                       input logic [7:0] proto, input logic [31:0] src,
                                       input logic [7:0] mt, input logic [7:0] mc,
                                       input logic [15:0] id, input logic [15:0] sq,
                                       input int ln);
        int hl;
        hl = int'(ihl) * 4;
        frame_bytes.delete();
        for (int i = 0; i < ln; i++) begin
            logic [7:0] b;
            b = 8'($urandom);
            if (i == hl)     b = mt;
            if (i == hl + 1) b = mc;
            if (i == hl + 4) b = id[15:8];
            if (i == hl + 5) b = id[7:0];
            if (i == hl + 6) b = sq[15:8];
            if (i == hl + 7) b = sq[7:0];
            if (i == 0)      b = {ver, ihl};
            if (i == 9)      b = proto;
            if (i >= 12 && i <= 15)
                b = src[8 * (15 - i) +: 8];
            frame_bytes.push_back(b);
        end
    endfunction

    // Random packet: mostly well-formed replies, the rest broken or plain noise.
    task automatic gen_random_frame();
        int unsigned r;
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [7:0]  mt;
        logic [7:0]  mc;
        logic [15:0] id;
        logic [15:0] sq;
        int          hl;
        int          ln;
        ver   = IP_VERSION_4;
        ihl   = ($urandom_range(0, 9) < 7) ? 4'd5 : 4'($urandom_range(5, 15));
        proto = IP_PROTO_ICMP;
        case ($urandom_range(0, 3))
            0:       mt = ICMP_ECHO_REPLY;
            1:       mt = ICMP_UNREACH;
            2:       mt = ICMP_TIME_EXCD;
            default: mt = 8'($urandom);
        endcase
        mc = ($urandom_range(0, 99) < 80) ? 8'h00 : 8'($urandom);
        id = ($urandom_range(0, 99) < 80) ? cls_ident : 16'($urandom);
        sq = ($urandom_range(0, 99) < 80) ? cls_seq : 16'($urandom);
        hl = int'(ihl) * 4;
        ln = hl + 8 + $urandom_range(0, 8);
        if ($urandom_range(0, 19) == 0)
            ln = hl + 8 + $urandom_range(0, 150);
        r = $urandom_range(0, 99);
        if (r >= 75) begin
            case (r % 5)
                0: ver = 4'($urandom);
                1: ihl = 4'($urandom_range(0, 4));
                2: proto = 8'($urandom);
                3: ln = $urandom_range(1, hl + 7);
                default: begin
                    ver   = 4'($urandom);
                    ihl   = 4'($urandom);
                    proto = 8'($urandom);
                    mt    = 8'($urandom);
                    mc    = 8'($urandom);
                    ln    = $urandom_range(1, 40);
                end
            endcase
        end
        fill_frame(ver, ihl, proto, 32'($urandom), mt, mc, id, sq, ln);
    endtask

    // Offers one byte, with a random gap beforehand while stalling is on, and waits for its transfer.
    task automatic drive_byte(input logic [7:0] b, input logic last);
        while (stall_enable && $urandom_range(0, 99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Sends frame_bytes as one packet, noting whether its reply is typed in.
    task automatic send_frame(input packet_note_t note);
        packet_notes.push_back(note);
        for (int i = 0; i < frame_bytes.size(); i++)
            drive_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // Holds the config channel valid until the write transfer completes.
    task automatic write_reg(input logic [7:0] index, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
    endtask

    // Stops the input and waits until every reply is in and the block has settled.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending_replies.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // Reprograms both registers, plus one write to an unused index, and sets the stall mode.
    task automatic set_phase(input logic [15:0] id, input logic [15:0] sq, input bit stalls);
        wait_idle();
        write_reg(CFG_EXPECTED_IDENT, id);
        write_reg(CFG_EXPECTED_SEQ, sq);
        write_reg(8'($urandom_range(2, 255)), 16'($urandom));
        cfg_valid <= 1'b0;
        @(posedge aclk);
        stall_enable = stalls;
    endtask

    task automatic report_mismatch(input string what, input logic [39:0] want,
                                   input logic [39:0] got);
        $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
        mismatch_count++;
    endtask

    // Result sink: m_tready drops at random while stalling is on.
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= stall_enable ? ($urandom_range(0, 99) >= 34) : 1'b1;
    end

    // Watches all three channels: updates the model and checks each result transfer.
    always @(posedge aclk) begin
        reply_t       predicted;
        reply_t       want;
        packet_note_t note;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_replies.size() == 0) begin
                    report_mismatch("result with none pending", 40'h0, m_tdata);
                end else begin
                    want = pending_replies.pop_front();
                    if (m_tdata[1:0] !== want.verdict)
                        report_mismatch("verdict", 40'(want.verdict), 40'(m_tdata[1:0]));
                    if (m_tdata[33:2] !== want.addr)
                        report_mismatch("source_addr", 40'(want.addr), 40'(m_tdata[33:2]));
                    if (m_tdata[39:34] !== 6'h00)
                        report_mismatch("tdata padding", 40'h0, 40'(m_tdata[39:34]));
                end
            end
            if (s_tvalid && s_tready) begin
                if (classify_byte(s_tdata, s_tlast, predicted)) begin
                    note = (packet_notes.size() != 0) ? packet_notes.pop_front() : '0;
                    pending_replies.push_back(note.use_fixed ? note.want : predicted);
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_EXPECTED_IDENT)
                    cls_ident = cfg_data;
                else if (cfg_index == CFG_EXPECTED_SEQ)
                    cls_seq = cfg_data;
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Main sequence: reset, directed table, then random phases over several settings.
    initial begin
        packet_note_t note;
        int           sent;
        clear_parse();
        cls_ident = '0;
        cls_seq   = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_PROBES; i++) begin
            fill_frame(PROBES[i].ver, PROBES[i].ihl, PROBES[i].proto, PROBES[i].src,
                       PROBES[i].mtype, PROBES[i].mcode, PROBES[i].ident, PROBES[i].seq,
                       int'(PROBES[i].len));
            note.use_fixed    = PROBES[i].fixed;
            note.want.verdict = PROBES[i].verdict;
            note.want.addr    = PROBES[i].addr;
            send_frame(note);
        end

        note = '0;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       set_phase(16'hFFFF, 16'hFFFF, 1'b1);
                1:       set_phase(16'($urandom), 16'($urandom), 1'b1);
                2:       set_phase(16'h0000, 16'h0000, 1'b0);
                3:       set_phase(16'($urandom), 16'($urandom), 1'b1);
                default: set_phase(16'h00FF, 16'hFF00, 1'b1);
            endcase
            sent = 0;
            while (sent < PHASE_BYTES) begin
                gen_random_frame();
                sent += frame_bytes.size();
                send_frame(note);
            end
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/icmprc_pkg.sv
sv/icmp_reply_classifier_core.sv
verif/testbench.sv
